@@ hw/rtl/apitc_pkg.sv @@
// ----------------------------------------------------------------------------
// apitc_pkg
// Shared types, register indexes and constants of the altitude PI thrust
// controller.
// ----------------------------------------------------------------------------
package apitc_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // fixed port widths
    localparam int FIELD_W  = 32;
    localparam int QUAT_W   = 16;
    localparam int DT_W     = 16;
    localparam int THRUST_W = 32;

    // configuration port
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 31;
    localparam int GAIN_W      = 31;
    localparam int MOTOR_W     = 29;

    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_POSITION = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_SPEED    = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_INTEGRAL = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ASCENT_LIMIT  = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DESCENT_LIMIT = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MOTOR_MIN     = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_MOTOR_MAX     = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_VEHICLE_MASS  = 4'd7;

    localparam logic [GAIN_W-1:0]  RST_SPEED_LIMIT = 31'd6553600;
    localparam logic [MOTOR_W-1:0] RST_MOTOR_MAX   = 29'd6553600;
    localparam logic [GAIN_W-1:0]  RST_MASS        = 31'd65536;

    // arithmetic
    localparam int MUL_B_W      = 32;
    localparam int DT_FRAC      = 16;
    localparam int R_FRAC       = 28;
    localparam int R33_W        = 34;
    localparam int NUM_CAP_LOG2 = 34;
    localparam int DIV_N_W      = 63;
    localparam int DIV_D_W      = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_SV,
        ST_MUL_II,
        ST_MUL_NUM,
        ST_SQ_W,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
    } unit_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

@@ hw/rtl/altitude_pi_thrust_control.sv @@
// ----------------------------------------------------------------------------
// altitude_pi_thrust_control
// Cascaded altitude PI loop producing collective thrust from one control tick.
// ----------------------------------------------------------------------------
// One tick is taken at a time. Nine products go through one bit-serial
// multiplier, each as a start step, the shift-add steps and a done step.
// The products are the P term, the integral step, the speed term, the
// integral term, the mass scaling and the four quaternion squares for R33.
// The thrust division then runs in a restoring divider at one quotient bit
// per cycle, again between a start step and a done step. A tilt fault skips
// the division. The block takes the next tick in the cycle after the result
// is loaded. The result sits in an output register, so a new tick is taken
// while it waits. The last step stalls only while an earlier result is
// still unclaimed. Configuration writes take effect at once.
module altitude_pi_thrust_control #(
    parameter int DATA_WIDTH = apitc_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = apitc_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_write_en,
    input  logic [apitc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [apitc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [apitc_pkg::FIELD_W-1:0] s_target_altitude,
    input  logic signed [apitc_pkg::FIELD_W-1:0] s_target_vert_speed,
    input  logic signed [apitc_pkg::FIELD_W-1:0] s_measured_altitude,
    input  logic signed [apitc_pkg::FIELD_W-1:0] s_measured_vert_speed,
    input  logic signed [apitc_pkg::QUAT_W-1:0]  s_quat_w,
    input  logic signed [apitc_pkg::QUAT_W-1:0]  s_quat_x,
    input  logic signed [apitc_pkg::QUAT_W-1:0]  s_quat_y,
    input  logic signed [apitc_pkg::QUAT_W-1:0]  s_quat_z,
    input  logic signed [apitc_pkg::FIELD_W-1:0] s_accel_feedforward,
    input  logic [apitc_pkg::DT_W-1:0]           s_time_step,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [apitc_pkg::THRUST_W-1:0] m_thrust_command,
    output logic                                 m_tilt_fault
);
    import apitc_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int WW = DW + 34;
    localparam int PW = DW + MUL_B_W;

    localparam logic signed [WW-1:0] SAT_HI  = (WW'(1) << (DW - 1)) - WW'(1);
    localparam logic signed [WW-1:0] SAT_LO  = -SAT_HI - WW'(1);
    localparam logic signed [WW-1:0] GRAVITY =
        WW'(((64'd981 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic signed [63:0]   NUM_CAP = 64'sd1 <<< NUM_CAP_LOG2;

    function automatic logic signed [DW-1:0] sat_w(input logic signed [WW-1:0] v);
        logic signed [DW-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[DW-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[DW-1:0];
        end else begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [WW-1:0] sx(input logic signed [DW-1:0] v);
        return WW'(v);
    endfunction

    // configuration
    logic [GAIN_W-1:0]  gain_position_reg, gain_speed_reg, gain_integral_reg;
    logic [GAIN_W-1:0]  ascent_limit_reg, descent_limit_reg, vehicle_mass_reg;
    logic [MOTOR_W-1:0] motor_min_reg, motor_max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_position_reg <= '0;
            gain_speed_reg    <= '0;
            gain_integral_reg <= '0;
            ascent_limit_reg  <= RST_SPEED_LIMIT;
            descent_limit_reg <= RST_SPEED_LIMIT;
            motor_min_reg     <= '0;
            motor_max_reg     <= RST_MOTOR_MAX;
            vehicle_mass_reg  <= RST_MASS;
        end else if (cfg_write_en) begin
            unique case (cfg_index)
                REG_GAIN_POSITION: gain_position_reg <= cfg_data[GAIN_W-1:0];
                REG_GAIN_SPEED:    gain_speed_reg    <= cfg_data[GAIN_W-1:0];
                REG_GAIN_INTEGRAL: gain_integral_reg <= cfg_data[GAIN_W-1:0];
                REG_ASCENT_LIMIT:  ascent_limit_reg  <= cfg_data[GAIN_W-1:0];
                REG_DESCENT_LIMIT: descent_limit_reg <= cfg_data[GAIN_W-1:0];
                REG_MOTOR_MIN:     motor_min_reg     <= cfg_data[MOTOR_W-1:0];
                REG_MOTOR_MAX:     motor_max_reg     <= cfg_data[MOTOR_W-1:0];
                REG_VEHICLE_MASS:  vehicle_mass_reg  <= cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // tick state
    state_t state_reg, state_next;
    logic   started_reg, started_next;

    logic signed [DW-1:0]     err_reg, t_vel_reg, m_vel_reg, ff_reg;
    logic signed [DW-1:0]     vcmd_reg, integ_reg, gacc_reg, num_reg;
    logic signed [WW-1:0]     accp_reg;
    logic signed [QUAT_W-1:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic [DT_W-1:0]          dt_reg;
    logic signed [R33_W-1:0]  r33_reg;
    logic signed [THRUST_W-1:0] thrust_reg;
    logic                     fault_reg;
    logic                     m_valid_reg;
    logic signed [THRUST_W-1:0] m_thrust_reg;
    logic                     m_fault_reg;

    // shared units
    unit_ctrl_t          mul_ctrl, div_ctrl;
    unit_stat_t          mul_stat, div_stat;
    logic [DW-1:0]       mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [PW-1:0]       mul_product;
    logic [DIV_N_W-1:0]  div_dividend, div_quotient;

    apitc_mul #(.DATA_WIDTH(DW)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mul_ctrl),
        .a_mag   (mul_a),
        .b       (mul_b),
        .stat    (mul_stat),
        .product (mul_product)
    );

    apitc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .divisor  (r33_reg[DIV_D_W-1:0]),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    // operand select
    logic signed [DW-1:0]     a_src;
    logic signed [QUAT_W-1:0] q_sel;
    logic [QUAT_W-1:0]        q_mag;
    logic                     square_op, mul_neg;

    always_comb begin
        q_sel     = qw_reg;
        square_op = 1'b0;
        a_src     = err_reg;
        mul_b     = MUL_B_W'(gain_position_reg);
        case (state_reg)
            ST_MUL_I:   mul_b = MUL_B_W'(dt_reg);
            ST_MUL_SV: begin
                a_src = sat_w(sx(vcmd_reg) - sx(m_vel_reg));
                mul_b = MUL_B_W'(gain_speed_reg);
            end
            ST_MUL_II: begin
                a_src = integ_reg;
                mul_b = MUL_B_W'(gain_integral_reg);
            end
            ST_MUL_NUM: begin
                a_src = gacc_reg;
                mul_b = MUL_B_W'(vehicle_mass_reg);
            end
            ST_SQ_W: begin
                q_sel = qw_reg;
                square_op = 1'b1;
            end
            ST_SQ_X: begin
                q_sel = qx_reg;
                square_op = 1'b1;
            end
            ST_SQ_Y: begin
                q_sel = qy_reg;
                square_op = 1'b1;
            end
            ST_SQ_Z: begin
                q_sel = qz_reg;
                square_op = 1'b1;
            end
            default: ;
        endcase
        q_mag = q_sel[QUAT_W-1] ? QUAT_W'(-q_sel) : QUAT_W'(q_sel);
        if (square_op) begin
            a_src = DW'(q_sel);
            mul_b = MUL_B_W'(q_mag);
        end
        mul_a   = a_src[DW-1] ? DW'(-a_src) : DW'(a_src);
        mul_neg = a_src[DW-1] && !square_op;
    end

    // product post-processing
    logic signed [WW-1:0]    prod_s, vw, acc_lo, acc_hi, accp_next;
    logic signed [DW-1:0]    prod_fb, prod_dt, vsat, vcmd_next, integ_next;
    logic signed [DW-1:0]    acc, gacc_next;
    logic signed [R33_W-1:0] sq;

    always_comb begin
        prod_s     = mul_neg ? -WW'(mul_product) : WW'(mul_product);
        prod_fb    = sat_w(prod_s >>> FRAC_BITS);
        prod_dt    = sat_w(prod_s >>> DT_FRAC);
        vsat       = sat_w(sx(prod_fb) + sx(t_vel_reg));
        vw         = sx(vsat);
        acc_lo     = -$signed(WW'(ascent_limit_reg));
        acc_hi     = $signed(WW'(descent_limit_reg));
        // lower bound first, upper bound wins
        if (vw < acc_lo) begin
            vw = acc_lo;
        end
        if (vw > acc_hi) begin
            vw = acc_hi;
        end
        vcmd_next  = vw[DW-1:0];
        integ_next = sat_w(sx(integ_reg) + sx(prod_dt));
        accp_next  = sx(ff_reg) + sx(prod_fb);
        acc        = sat_w(accp_reg + sx(prod_fb));
        gacc_next  = sat_w(GRAVITY - sx(acc));
        sq         = $signed({1'b0, mul_product[R33_W-2:0]});
    end

    // thrust division
    logic signed [63:0] num_w, num_mag, quo_s, lo4, hi4, thrust_w;
    logic               num_neg;

    always_comb begin
        num_neg = num_reg[DW-1];
        num_w   = 64'(num_reg);
        if (num_w > NUM_CAP) begin
            num_w = NUM_CAP;
        end
        if (num_w < -NUM_CAP) begin
            num_w = -NUM_CAP;
        end
        num_mag      = num_neg ? -num_w : num_w;
        div_dividend = DIV_N_W'(num_mag <<< R_FRAC);
        lo4          = $signed(64'({motor_min_reg, 2'b00}));
        hi4          = $signed(64'({motor_max_reg, 2'b00}));
        quo_s        = $signed({1'b0, div_quotient});
        thrust_w     = num_neg ? -quo_s : quo_s;
        if (thrust_w < lo4) begin
            thrust_w = lo4;
        end
        if (thrust_w > hi4) begin
            thrust_w = hi4;
        end
    end

    // sequencer
    logic in_xfer, out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            started_reg <= started_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        started_next   = started_reg;
        mul_ctrl.start = 1'b0;
        div_ctrl.start = 1'b0;
        s_ready        = 1'b0;
        out_load       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_MUL_P;
                end
            end
            ST_MUL_P, ST_MUL_I, ST_MUL_SV, ST_MUL_II, ST_MUL_NUM,
            ST_SQ_W, ST_SQ_X, ST_SQ_Y, ST_SQ_Z: begin
                if (!started_reg) begin
                    mul_ctrl.start = 1'b1;
                    started_next   = 1'b1;
                end else if (mul_stat.done) begin
                    started_next = 1'b0;
                    unique case (state_reg)
                        ST_MUL_P:   state_next = ST_MUL_I;
                        ST_MUL_I:   state_next = ST_MUL_SV;
                        ST_MUL_SV:  state_next = ST_MUL_II;
                        ST_MUL_II:  state_next = ST_MUL_NUM;
                        ST_MUL_NUM: state_next = ST_SQ_W;
                        ST_SQ_W:    state_next = ST_SQ_X;
                        ST_SQ_X:    state_next = ST_SQ_Y;
                        ST_SQ_Y:    state_next = ST_SQ_Z;
                        default:    state_next = ST_DIV;
                    endcase
                end
            end
            ST_DIV: begin
                if (!started_reg) begin
                    if (r33_reg <= 0) begin
                        state_next = ST_DONE;
                    end else begin
                        div_ctrl.start = 1'b1;
                        started_next   = 1'b1;
                    end
                end else if (div_stat.done) begin
                    started_next = 1'b0;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign in_xfer = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
        end else if (mul_stat.done && state_reg == ST_MUL_I) begin
            integ_reg <= integ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            err_reg   <= sat_w(sx(sat_w(WW'(s_target_altitude)))
                               - sx(sat_w(WW'(s_measured_altitude))));
            t_vel_reg <= sat_w(WW'(s_target_vert_speed));
            m_vel_reg <= sat_w(WW'(s_measured_vert_speed));
            ff_reg    <= sat_w(WW'(s_accel_feedforward));
            qw_reg    <= s_quat_w;
            qx_reg    <= s_quat_x;
            qy_reg    <= s_quat_y;
            qz_reg    <= s_quat_z;
            dt_reg    <= s_time_step;
            r33_reg   <= '0;
        end
        if (mul_stat.done) begin
            case (state_reg)
                ST_MUL_P:   vcmd_reg <= vcmd_next;
                ST_MUL_SV:  accp_reg <= accp_next;
                ST_MUL_II:  gacc_reg <= gacc_next;
                ST_MUL_NUM: num_reg  <= prod_fb;
                ST_SQ_W, ST_SQ_Z: r33_reg <= r33_reg + sq;
                ST_SQ_X, ST_SQ_Y: r33_reg <= r33_reg - sq;
                default: ;
            endcase
        end
        if (state_reg == ST_DIV && !started_reg && r33_reg <= 0) begin
            thrust_reg <= hi4[THRUST_W-1:0];
            fault_reg  <= 1'b1;
        end
        if (div_stat.done) begin
            thrust_reg <= thrust_w[THRUST_W-1:0];
            fault_reg  <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_thrust_reg <= thrust_reg;
            m_fault_reg  <= fault_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_thrust_command = m_thrust_reg;
    assign m_tilt_fault     = m_fault_reg;

    // checks
    a_mul_done_in_mul_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_stat.done |-> !div_stat.busy
            && (state_reg == ST_MUL_P || state_reg == ST_MUL_I
            || state_reg == ST_MUL_SV || state_reg == ST_MUL_II
            || state_reg == ST_MUL_NUM || state_reg == ST_SQ_W
            || state_reg == ST_SQ_X || state_reg == ST_SQ_Y
            || state_reg == ST_SQ_Z))
        else $error("multiplier finished outside a product step");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> state_reg == ST_DIV && !mul_stat.busy)
        else $error("divider finished outside the division step");

    a_fault_max_thrust: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_fault_reg |->
            m_thrust_reg == $signed(THRUST_W'({motor_max_reg, 2'b00})))
        else $error("tilt fault without maximum thrust");

    a_thrust_in_limits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_fault_reg && motor_min_reg <= motor_max_reg |->
            m_thrust_reg >= $signed(THRUST_W'({motor_min_reg, 2'b00}))
            && m_thrust_reg <= $signed(THRUST_W'({motor_max_reg, 2'b00})))
        else $error("thrust outside motor limits");

endmodule

@@ hw/rtl/apitc_mul.sv @@
// ----------------------------------------------------------------------------
// apitc_mul
// Bit-serial unsigned multiplier: one multiplier bit per cycle, shift-add.
// ----------------------------------------------------------------------------
module apitc_mul #(
    parameter int DATA_WIDTH = apitc_pkg::DATA_WIDTH_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  apitc_pkg::unit_ctrl_t                   ctrl,
    input  logic [DATA_WIDTH-1:0]                   a_mag,
    input  logic [apitc_pkg::MUL_B_W-1:0]           b,
    output apitc_pkg::unit_stat_t                   stat,
    output logic [DATA_WIDTH+apitc_pkg::MUL_B_W-1:0] product
);
    import apitc_pkg::*;

    localparam int DW    = DATA_WIDTH;
    localparam int CNT_W = $clog2(MUL_B_W);

    logic [DW-1:0]      a_reg;
    logic [DW:0]        hi_reg, hi_next;
    logic [MUL_B_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg, done_reg;
    logic [DW:0]        sum;

    always_comb begin
        sum     = hi_reg + (lo_reg[0] ? {1'b0, a_reg} : {(DW+1){1'b0}});
        hi_next = {1'b0, sum[DW:1]};
        lo_next = {sum[0], lo_reg[MUL_B_W-1:1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MUL_B_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            a_reg  <= a_mag;
            hi_reg <= '0;
            lo_reg <= b;
        end else if (busy_reg) begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = {hi_reg[DW-1:0], lo_reg};

endmodule

@@ hw/rtl/apitc_div.sv @@
// ----------------------------------------------------------------------------
// apitc_div
// Restoring divider: one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module apitc_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  apitc_pkg::unit_ctrl_t          ctrl,
    input  logic [apitc_pkg::DIV_N_W-1:0]  dividend,
    input  logic [apitc_pkg::DIV_D_W-1:0]  divisor,
    output apitc_pkg::unit_stat_t          stat,
    output logic [apitc_pkg::DIV_N_W-1:0]  quotient
);
    import apitc_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W);

    logic [DIV_D_W-1:0] d_reg;
    logic [DIV_D_W-1:0] rem_reg, rem_next;
    logic [DIV_N_W-1:0] dq_reg, dq_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg, done_reg;
    logic [DIV_D_W:0]   trial, diff;
    logic               fits;

    always_comb begin
        trial    = {rem_reg, dq_reg[DIV_N_W-1]};
        diff     = trial - {1'b0, d_reg};
        fits     = !diff[DIV_D_W];
        rem_next = fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
        dq_next  = {dq_reg[DIV_N_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_N_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            d_reg   <= divisor;
            rem_reg <= '0;
            dq_reg  <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dq_reg;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the altitude PI thrust controller. Control ticks
// go in over valid/ready in random bursts, results come back under random
// backpressure, and each result is checked against an in-bench fixed-point
// model of the loop across several gain, limit and mass settings.
// ----------------------------------------------------------------------------
module tb;
    import apitc_pkg::*;

    localparam longint GRAVITY_FX = ((64'sd981 <<< 16) + 50) / 100;
    localparam longint CYCLE_LIMIT = 6000000;

    typedef struct {
        logic signed [31:0] tgt_alt;
        logic signed [31:0] tgt_vel;
        logic signed [31:0] meas_alt;
        logic signed [31:0] meas_vel;
        logic signed [15:0] qw;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [31:0] accel_ff;
        logic [15:0]        dt;
    } tick_t;

    typedef struct {
        logic signed [31:0] thrust;
        logic               fault;
    } thrust_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_target_altitude = '0;
    logic signed [31:0] s_target_vert_speed = '0;
    logic signed [31:0] s_measured_altitude = '0;
    logic signed [31:0] s_measured_vert_speed = '0;
    logic signed [15:0] s_quat_w = '0;
    logic signed [15:0] s_quat_x = '0;
    logic signed [15:0] s_quat_y = '0;
    logic signed [15:0] s_quat_z = '0;
    logic signed [31:0] s_accel_feedforward = '0;
    logic [15:0] s_time_step = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_thrust_command;
    logic m_tilt_fault;

    altitude_pi_thrust_control dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // model copy of registers and loop state
    longint k_pos, k_vel, k_int, up_lim, down_lim, mot_lo, mot_hi, mass;
    longint alt_integral;

    tick_t   pending_ticks[$];
    thrust_t expected_thrust[$];
    int  errors = 0;
    int  checked = 0;
    int  faults_seen = 0;
    bit  gaps_on = 1'b1;
    bit  stalls_on = 1'b1;
    int  idle_left = 0;
    int  burst_left = 0;
    longint cycles = 0;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // exact product, floor shift, saturate
    function automatic longint mul_floor(longint a, longint b, int sh);
        logic signed [127:0] pa, pb, p;
        pa = 128'(a);
        pb = 128'(b);
        p = (pa * pb) >>> sh;
        if (p > 128'sd2147483647) return 64'sd2147483647;
        if (p < -128'sd2147483648) return -64'sd2147483648;
        return longint'(p);
    endfunction

    function automatic thrust_t predict_thrust(tick_t t);
        thrust_t r;
        longint err, vcmd, acc, num, r33, thr;
        err = sat32(longint'(t.tgt_alt) - longint'(t.meas_alt));
        vcmd = sat32(mul_floor(err, k_pos, 16) + longint'(t.tgt_vel));
        if (vcmd < -up_lim) vcmd = -up_lim;
        if (vcmd > down_lim) vcmd = down_lim;
        alt_integral = sat32(alt_integral + mul_floor(err, longint'(t.dt), 16));
        acc = sat32(longint'(t.accel_ff)
                    + mul_floor(sat32(vcmd - longint'(t.meas_vel)), k_vel, 16)
                    + mul_floor(alt_integral, k_int, 16));
        num = mul_floor(sat32(GRAVITY_FX - acc), mass, 16);
        r33 = longint'(t.qw) * t.qw - longint'(t.qx) * t.qx
            - longint'(t.qy) * t.qy + longint'(t.qz) * t.qz;
        r.fault = (r33 <= 0);
        if (r.fault) begin
            thr = 4 * mot_hi;
        end else begin
            thr = (num * (64'sd1 <<< 28)) / r33;
            if (thr < 4 * mot_lo) thr = 4 * mot_lo;
            if (thr > 4 * mot_hi) thr = 4 * mot_hi;
        end
        r.thrust = thr[31:0];
        return r;
    endfunction

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_GAIN_POSITION: k_pos = longint'(val);
            REG_GAIN_SPEED:    k_vel = longint'(val);
            REG_GAIN_INTEGRAL: k_int = longint'(val);
            REG_ASCENT_LIMIT:  up_lim = longint'(val);
            REG_DESCENT_LIMIT: down_lim = longint'(val);
            REG_MOTOR_MIN:     mot_lo = longint'(val[MOTOR_W-1:0]);
            REG_MOTOR_MAX:     mot_hi = longint'(val[MOTOR_W-1:0]);
            REG_VEHICLE_MASS:  mass = longint'(val);
            default: ;
        endcase
    endtask

    task automatic write_all(longint kp, longint kv, longint ki, longint up,
                             longint dn, longint lo, longint hi, longint m);
        write_reg(REG_GAIN_POSITION, CFG_DATA_W'(kp));
        write_reg(REG_GAIN_SPEED, CFG_DATA_W'(kv));
        write_reg(REG_GAIN_INTEGRAL, CFG_DATA_W'(ki));
        write_reg(REG_ASCENT_LIMIT, CFG_DATA_W'(up));
        write_reg(REG_DESCENT_LIMIT, CFG_DATA_W'(dn));
        write_reg(REG_MOTOR_MIN, CFG_DATA_W'(lo));
        write_reg(REG_MOTOR_MAX, CFG_DATA_W'(hi));
        write_reg(REG_VEHICLE_MASS, CFG_DATA_W'(m));
        @(posedge aclk);
        cfg_write_en <= 1'b0;
    endtask

    function automatic tick_t make_tick(longint ta, longint tv, longint ma, longint mv,
                                        int w, int x, int y, int z,
                                        longint ff, int dt);
        tick_t t;
        t.tgt_alt = 32'(ta); t.tgt_vel = 32'(tv); t.meas_alt = 32'(ma); t.meas_vel = 32'(mv);
        t.qw = 16'(w); t.qx = 16'(x); t.qy = 16'(y); t.qz = 16'(z);
        t.accel_ff = 32'(ff); t.dt = 16'(dt);
        return t;
    endfunction

    function automatic logic signed [31:0] rand_field();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    function automatic logic signed [15:0] rand_quat();
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
    endfunction

    function automatic tick_t rand_tick();
        tick_t t;
        t.tgt_alt = rand_field();
        t.tgt_vel = rand_field();
        t.meas_alt = ($urandom_range(0, 1) != 0) ? t.tgt_alt + rand_field() >>> 4
                                                 : rand_field();
        t.meas_vel = rand_field();
        // mostly near level so the divide path dominates
        if ($urandom_range(0, 3) != 0) begin
            t.qw = 16'sd14000 + $signed(16'($urandom_range(0, 2384)));
            t.qx = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
            t.qy = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
            t.qz = rand_quat();
        end else begin
            t.qw = rand_quat(); t.qx = rand_quat(); t.qy = rand_quat(); t.qz = rand_quat();
        end
        t.accel_ff = rand_field();
        t.dt = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 700));
        return t;
    endfunction

    task automatic drain();
        while (pending_ticks.size() != 0 || expected_thrust.size() != 0 || s_valid)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic queue_random(int n);
        repeat (n) pending_ticks.push_back(rand_tick());
    endtask

    // source side: bursts with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (idle_left > 0) begin
                idle_left <= idle_left - 1;
                s_valid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
                tick_t t;
                t = pending_ticks.pop_front();
                expected_thrust.push_back(predict_thrust(t));
                s_target_altitude <= t.tgt_alt;
                s_target_vert_speed <= t.tgt_vel;
                s_measured_altitude <= t.meas_alt;
                s_measured_vert_speed <= t.meas_vel;
                s_quat_w <= t.qw;
                s_quat_x <= t.qx;
                s_quat_y <= t.qy;
                s_quat_z <= t.qz;
                s_accel_feedforward <= t.accel_ff;
                s_time_step <= t.dt;
                s_valid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 24);
                    idle_left <= gaps_on ? $urandom_range(0, 400) : 0;
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // sink side: check each transfer, stall at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_thrust.size() == 0) begin
                    $display("%0t: result with nothing expected: thrust %0d fault %0b",
                             $time, m_thrust_command, m_tilt_fault);
                    errors++;
                end else begin
                    thrust_t e;
                    e = expected_thrust.pop_front();
                    checked++;
                    if (e.fault) faults_seen++;
                    if (m_thrust_command !== e.thrust) begin
                        $display("%0t: thrust expected %0d actual %0d",
                                 $time, e.thrust, m_thrust_command);
                        errors++;
                    end
                    if (m_tilt_fault !== e.fault) begin
                        $display("%0t: tilt fault expected %0b actual %0b",
                                 $time, e.fault, m_tilt_fault);
                        errors++;
                    end
                end
            end
            m_ready <= stalls_on ? ($urandom_range(0, 2) == 0) : 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycles, expected_thrust.size());
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        k_pos = 0; k_vel = 0; k_int = 0;
        up_lim = longint'(RST_SPEED_LIMIT); down_lim = longint'(RST_SPEED_LIMIT);
        mot_lo = 0; mot_hi = longint'(RST_MOTOR_MAX); mass = longint'(RST_MASS);
        alt_integral = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings, directed corners
        pending_ticks.push_back(make_tick(0, 0, 0, 0, 16384, 0, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(0, 0, 0, 0, 8192, 8192, 0, 0, 0, 100));
        pending_ticks.push_back(make_tick(0, 0, 0, 0, 0, 16384, 0, 0, 0, 100));
        pending_ticks.push_back(make_tick(0, 0, 0, 0, -16384, 16384, -16384, 16384, 0, 9));
        pending_ticks.push_back(make_tick(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -32'sh8000_0000,
                                -32'sh8000_0000, 16384, 0, 0, 0, 32'sh7FFF_FFFF, 16'hFFFF));
        pending_ticks.push_back(make_tick(-32'sh8000_0000, -32'sh8000_0000, 32'sh7FFF_FFFF,
                                32'sh7FFF_FFFF, 16384, 0, 0, 0, -32'sh8000_0000, 16'hFFFF));
        pending_ticks.push_back(make_tick(0, 0, 0, 0, 1, 0, 0, 0, -32'sh8000_0000, 1));
        pending_ticks.push_back(make_tick(0, 0, 0, 0, -32768, -32768, -32768, -32768,
                                0, 16'h8000));
        pending_ticks.push_back(make_tick(0, 0, 0, 0, 32767, 0, 0, 32767, 32'sh7FFF_FFFF, 0));
        pending_ticks.push_back(make_tick(65536, 0, 0, 0, 11585, 11585, 0, 0, 0, 655));
        drain();

        // gains high, tight speed limits, unknown index ignored
        write_all(32'h7FFF_FFFF, 131072, 65536, 0, 0, 29'h1FFF_FFFF, 29'h1FFF_FFFF,
                  32'h7FFF_FFFF);
        write_reg(4'd9, 31'h1234_5678);
        write_reg(4'd15, 31'h7FFF_FFFF);
        @(posedge aclk);
        cfg_write_en <= 1'b0;
        pending_ticks.push_back(make_tick(32'sh7FFF_FFFF, 0, -32'sh8000_0000, 0,
                                16384, 0, 0, 0, 0, 16'hFFFF));
        pending_ticks.push_back(make_tick(-32'sh8000_0000, 0, 32'sh7FFF_FFFF, 0,
                                16384, 0, 0, 0, 0, 16'hFFFF));
        queue_random(150);
        drain();

        // every register at its top value but the motor minimum, which is zero
        write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 0, 29'h1FFF_FFFF, 32'h7FFF_FFFF);
        gaps_on = 1'b0;
        queue_random(150);
        drain();

        // inverted motor limits: upper clamp must win
        write_all(65536, 32768, 4096, 6553600, 3276800, 29'h0100_0000, 29'h0001_0000,
                  98304);
        gaps_on = 1'b1;
        stalls_on = 1'b0;
        queue_random(150);
        drain();

        // plausible flight settings, varied per phase
        stalls_on = 1'b1;
        for (int ph = 0; ph < 8; ph++) begin
            write_all(longint'($urandom_range(0, 262144)), longint'($urandom_range(0, 262144)),
                      longint'($urandom_range(0, 65536)),
                      longint'($urandom_range(0, 20_000_000)),
                      longint'($urandom_range(0, 20_000_000)),
                      longint'($urandom_range(0, 300_000)),
                      longint'($urandom_range(100_000, 29'h1FFF_FFFF)),
                      longint'($urandom_range(1, 1_000_000)));
            gaps_on = (ph % 3) != 2;
            stalls_on = (ph % 4) != 3;
            queue_random(150);
            drain();
        end

        // everything at zero
        write_all(0, 0, 0, 0, 0, 0, 0, 0);
        queue_random(50);
        drain();

        repeat (500) @(posedge aclk);
        if (expected_thrust.size() != 0) begin
            $display("%0d results never arrived", expected_thrust.size());
            errors++;
        end
        $display("checked %0d thrust results (%0d with tilt fault) over 13 register settings",
                 checked, faults_seen);
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
